@@ sv/mcm_pkg.sv @@
// Package for the motor command mode controller.
// Holds command, mode and response codes, duty constants and shared structs.
`default_nettype none

package mcm_pkg;

  typedef enum logic [3:0] {
    CMD_ON     = 4'd0,
    CMD_OFF    = 4'd1,
    CMD_SPEED  = 4'd2,
    CMD_GPIO   = 4'd3,
    CMD_PWM    = 4'd4,
    CMD_FWD    = 4'd5,
    CMD_REV    = 4'd6,
    CMD_STATUS = 4'd7,
    CMD_SETRPM = 4'd8,
    CMD_AUTO   = 4'd9,
    CMD_SELECT = 4'd10,
    CMD_FAULT  = 4'd11
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_STOP  = 3'd0,
    MODE_PWM   = 3'd1,
    MODE_GPIO  = 3'd2,
    MODE_FWD   = 3'd3,
    MODE_REV   = 3'd4,
    MODE_ERROR = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    RESP_OK      = 3'd0,
    RESP_INVALID = 3'd1,
    RESP_RECOVER = 3'd2,
    RESP_RANGE   = 3'd3,
    RESP_BADID   = 3'd4,
    RESP_STATUS  = 3'd5,
    RESP_FAULT   = 3'd6
  } resp_e;

  localparam logic [9:0]  START_DUTY = 10'd200;
  localparam logic [9:0]  MAX_DUTY   = 10'd1000;
  localparam logic [9:0]  MAX_PCT    = 10'd100;
  localparam logic [13:0] DUTY_STEP  = 14'd10;
  localparam logic [9:0]  MAX_RPM    = 10'd1000;
  localparam logic [9:0]  MOTOR_ONE_ID = 10'd1;
  localparam logic [9:0]  MOTOR_TWO_ID = 10'd2;

  typedef struct packed {
    mode_e      mode;
    logic       motor;
    logic       loop_closed;
    logic [9:0] rpm;
  } state_t;

  typedef struct packed {
    resp_e      resp;
    logic       pwm_write;
    logic [9:0] pwm_value;
    logic       stop_pulse;
    logic       loop_reset;
  } act_t;

endpackage

`default_nettype wire

@@ sv/mcm_step.sv @@
// Next-state and action logic for one motor command.
// Depends on mcm_pkg for codes, constants and the state/action structs.
`default_nettype none

module mcm_step import mcm_pkg::*; (
  input  logic [3:0] func_i,
  input  logic [9:0] param_i,
  input  state_t     state_i,
  output state_t     state_o,
  output act_t       act_o
);

  cmd_e        cmd;
  logic [13:0] duty_full;
  logic [9:0]  duty;
  logic        drive_cmd;

  assign cmd       = cmd_e'(func_i);
  assign duty_full = 14'(param_i) * DUTY_STEP;
  assign duty      = (duty_full > 14'(MAX_DUTY)) ? MAX_DUTY : duty_full[9:0];

  // commands that go through the mode machine; speed only when in range
  assign drive_cmd = (cmd inside {CMD_ON, CMD_OFF, CMD_GPIO, CMD_PWM, CMD_FWD, CMD_REV,
                                  CMD_STATUS, CMD_FAULT}) ||
                     ((cmd == CMD_SPEED) && (param_i <= MAX_PCT));

  // next state
  always_comb begin
    state_o = state_i;
    if (drive_cmd) begin
      if (state_i.mode == MODE_ERROR) begin
        if (cmd == CMD_ON) state_o.mode = MODE_STOP;
      end else if (cmd == CMD_FAULT) begin
        state_o.mode = MODE_ERROR;
      end else begin
        case (state_i.mode)
          MODE_STOP: begin
            if (cmd inside {CMD_ON, CMD_PWM}) state_o.mode = MODE_PWM;
            else if (cmd == CMD_GPIO)         state_o.mode = MODE_GPIO;
          end
          MODE_PWM: begin
            if (cmd == CMD_OFF)       state_o.mode = MODE_STOP;
            else if (cmd == CMD_GPIO) state_o.mode = MODE_GPIO;
          end
          MODE_GPIO: begin
            if (cmd == CMD_OFF)      state_o.mode = MODE_STOP;
            else if (cmd == CMD_PWM) state_o.mode = MODE_PWM;
          end
          MODE_FWD: begin
            if (cmd == CMD_OFF)       state_o.mode = MODE_STOP;
            else if (cmd == CMD_REV)  state_o.mode = MODE_REV;
            else if (cmd == CMD_GPIO) state_o.mode = MODE_GPIO;
          end
          MODE_REV: begin
            if (cmd == CMD_OFF)       state_o.mode = MODE_STOP;
            else if (cmd == CMD_FWD)  state_o.mode = MODE_FWD;
            else if (cmd == CMD_GPIO) state_o.mode = MODE_GPIO;
          end
          default: ;
        endcase
      end
    end

    case (cmd)
      CMD_SETRPM: begin
        if (param_i <= MAX_RPM) begin
          state_o.rpm         = param_i;
          state_o.loop_closed = 1'b1;
        end
      end
      CMD_AUTO: state_o.loop_closed = 1'b0;
      CMD_SELECT: begin
        if (param_i == MOTOR_ONE_ID)      state_o.motor = 1'b0;
        else if (param_i == MOTOR_TWO_ID) state_o.motor = 1'b1;
      end
      default: ;
    endcase
  end

  // response and motor actions
  always_comb begin
    act_o            = '0;
    act_o.resp       = RESP_INVALID;

    case (cmd)
      CMD_SPEED: begin
        if (param_i > MAX_PCT) act_o.resp = RESP_RANGE;
      end
      CMD_SETRPM: begin
        if (param_i > MAX_RPM) begin
          act_o.resp = RESP_RANGE;
        end else begin
          act_o.resp       = RESP_OK;
          act_o.loop_reset = 1'b1;
        end
      end
      CMD_AUTO: act_o.resp = RESP_OK;
      CMD_SELECT: begin
        act_o.resp = (param_i == MOTOR_ONE_ID || param_i == MOTOR_TWO_ID) ? RESP_OK
                                                                           : RESP_BADID;
      end
      default: ;
    endcase

    if (drive_cmd) begin
      if (state_i.mode == MODE_ERROR) begin
        if (cmd == CMD_ON) begin
          act_o.resp       = RESP_OK;
          act_o.stop_pulse = 1'b1;
        end else begin
          act_o.resp = RESP_RECOVER;
        end
      end else if (cmd == CMD_FAULT) begin
        act_o.resp       = RESP_FAULT;
        act_o.stop_pulse = 1'b1;
      end else begin
        case (state_i.mode)
          MODE_STOP: begin
            if (cmd == CMD_ON) begin
              act_o.resp      = RESP_OK;
              act_o.pwm_write = 1'b1;
              act_o.pwm_value = START_DUTY;
            end else if (cmd inside {CMD_GPIO, CMD_PWM}) begin
              act_o.resp = RESP_OK;
            end
          end
          MODE_PWM: begin
            if (cmd == CMD_OFF) begin
              act_o.resp       = RESP_OK;
              act_o.stop_pulse = 1'b1;
            end else if (cmd == CMD_SPEED) begin
              act_o.resp      = RESP_OK;
              act_o.pwm_write = 1'b1;
              act_o.pwm_value = duty;
            end else if (cmd inside {CMD_FWD, CMD_REV, CMD_GPIO}) begin
              act_o.resp = RESP_OK;
            end else if (cmd == CMD_STATUS) begin
              act_o.resp = RESP_STATUS;
            end
          end
          MODE_GPIO: begin
            if (cmd == CMD_OFF) begin
              act_o.resp       = RESP_OK;
              act_o.stop_pulse = 1'b1;
            end else if (cmd inside {CMD_FWD, CMD_REV, CMD_PWM}) begin
              act_o.resp = RESP_OK;
            end else if (cmd == CMD_STATUS) begin
              act_o.resp = RESP_STATUS;
            end
          end
          MODE_FWD, MODE_REV: begin
            if (cmd == CMD_OFF) begin
              act_o.resp       = RESP_OK;
              act_o.stop_pulse = 1'b1;
            end else if (cmd == CMD_SPEED) begin
              act_o.resp      = RESP_OK;
              act_o.pwm_write = 1'b1;
              act_o.pwm_value = duty;
            end else if ((cmd == CMD_REV && state_i.mode == MODE_FWD) ||
                         (cmd == CMD_FWD && state_i.mode == MODE_REV) ||
                         (cmd == CMD_GPIO) || (cmd == CMD_PWM)) begin
              act_o.resp = RESP_OK;
            end else if (cmd == CMD_STATUS) begin
              act_o.resp = RESP_STATUS;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/motor_command_mode_fsm.sv @@
// Motor command mode controller: one command word in, one response word out.
// A command passes the input register, then the result register, before out_valid_o rises.
// Throughput: one command per cycle while out_ready_i is high; the drive state updates as
// a command moves from input register to result register, so consecutive commands see each other.
// Reset (rst_ni low, async): stop mode, motor one, auto pwm, target rpm zero, no words held.
// Depends on mcm_pkg and mcm_step.
`default_nettype none

module motor_command_mode_fsm import mcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] func_i,
  input  logic [9:0] param_i,

  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] resp_code_o,
  output logic [2:0] drive_state_o,
  output logic       pwm_write_o,
  output logic [9:0] pwm_value_o,
  output logic       stop_pulse_o,
  output logic       motor_index_o,
  output logic       loop_reset_o,
  output logic       closed_loop_o,
  output logic [9:0] target_speed_o
);

  // input register
  logic       in_valid_q;
  logic [3:0] func_q;
  logic [9:0] param_q;

  // drive state
  state_t state_q, state_d;
  act_t   act;

  // result register
  logic   out_valid_q;
  act_t   out_act_q;
  state_t out_state_q;

  logic advance;

  // a held command moves on whenever the result register is empty or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload: load only on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q  <= func_i;
      param_q <= param_i;
    end
  end

  mcm_step u_step (
    .func_i  (func_q),
    .param_i (param_q),
    .state_i (state_q),
    .state_o (state_d),
    .act_o   (act)
  );

  // commit the new drive state only when the command leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: MODE_STOP, motor: 1'b0, loop_closed: 1'b0, rpm: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_act_q   <= act;
      out_state_q <= state_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign resp_code_o    = out_act_q.resp;
  assign drive_state_o  = out_state_q.mode;
  assign pwm_write_o    = out_act_q.pwm_write;
  assign pwm_value_o    = out_act_q.pwm_value;
  assign stop_pulse_o   = out_act_q.stop_pulse;
  assign motor_index_o  = out_state_q.motor;
  assign loop_reset_o   = out_act_q.loop_reset;
  assign closed_loop_o  = out_state_q.loop_closed;
  assign target_speed_o = out_state_q.rpm;

endmodule

`default_nettype wire

@@ sv/mcm_checker.sv @@
// Port-level checks for the motor command mode controller, bound to the top level.
// Depends on mcm_pkg for response and mode codes.
`default_nettype none

module mcm_assert import mcm_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [2:0] resp_code_o,
  input wire logic [2:0] drive_state_o,
  input wire logic       pwm_write_o,
  input wire logic [9:0] pwm_value_o,
  input wire logic       stop_pulse_o,
  input wire logic       loop_reset_o,
  input wire logic       closed_loop_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(resp_code_o) &&
      $stable(drive_state_o) && $stable(pwm_value_o) && $stable(stop_pulse_o))
    else $error("stalled result word changed");

  // duty is zero unless a write is requested
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pwm_write_o |-> pwm_value_o == 10'd0)
    else $error("pwm_value without pwm_write");

  // a stop never comes with a duty write and lands in stop or error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stop_pulse_o |-> !pwm_write_o &&
      (drive_state_o == MODE_STOP || drive_state_o == MODE_ERROR))
    else $error("stop pulse with bad state or duty write");

  // fault response enters error mode with a stop pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && resp_code_o == RESP_FAULT |-> drive_state_o == MODE_ERROR && stop_pulse_o)
    else $error("fault without error mode");

  // loop reset only on accepted set_rpm, which closes the loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && loop_reset_o |-> closed_loop_o && resp_code_o == RESP_OK)
    else $error("loop reset without closed loop");

endmodule

bind motor_command_mode_fsm mcm_assert u_mcm_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .resp_code_o   (resp_code_o),
  .drive_state_o (drive_state_o),
  .pwm_write_o   (pwm_write_o),
  .pwm_value_o   (pwm_value_o),
  .stop_pulse_o  (stop_pulse_o),
  .loop_reset_o  (loop_reset_o),
  .closed_loop_o (closed_loop_o)
);

`default_nettype wire

@@ tb/sv/mcm_checker.sv @@
// Checker for the motor command mode controller: watches both channels,
// predicts each response word and compares it field by field. Needs mcm_pkg.
`timescale 1ns / 1ps

module mcm_checker import mcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [3:0] func_i,
  input  logic [9:0] param_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [2:0] resp_code_i,
  input  logic [2:0] drive_state_i,
  input  logic       pwm_write_i,
  input  logic [9:0] pwm_value_i,
  input  logic       stop_pulse_i,
  input  logic       motor_index_i,
  input  logic       loop_reset_i,
  input  logic       closed_loop_i,
  input  logic [9:0] target_speed_i,
  output int         mismatch_count_o,
  output int         pending_o
);

  typedef struct packed {
    resp_e      resp;
    mode_e      mode;
    logic       pwm_write;
    logic [9:0] pwm_value;
    logic       stop_pulse;
    logic       motor;
    logic       loop_reset;
    logic       loop_closed;
    logic [9:0] rpm;
  } cmd_response_t;

  // shadow copy of the controller state
  mode_e       model_mode;
  logic        model_motor;
  logic        model_loop;
  logic [9:0]  model_rpm;

  cmd_response_t pending_responses[$];
  cmd_response_t want;
  int            word_idx;

  assign pending_o = pending_responses.size();

  function automatic cmd_response_t predict_response(logic [3:0] f, logic [9:0] p);
    cmd_response_t r;
    logic [13:0]   duty;
    r = '0;
    duty = p * DUTY_STEP;
    if (duty > MAX_DUTY) duty = MAX_DUTY;
    r.resp = RESP_INVALID;
    case (f)
      CMD_SETRPM: begin
        if (p > MAX_RPM) begin
          r.resp = RESP_RANGE;
        end else begin
          model_rpm    = p;
          model_loop   = 1'b1;
          r.loop_reset = 1'b1;
          r.resp       = RESP_OK;
        end
      end
      CMD_AUTO: begin
        model_loop = 1'b0;
        r.resp     = RESP_OK;
      end
      CMD_SELECT: begin
        if (p == MOTOR_ONE_ID) begin
          model_motor = 1'b0;
          r.resp      = RESP_OK;
        end else if (p == MOTOR_TWO_ID) begin
          model_motor = 1'b1;
          r.resp      = RESP_OK;
        end else begin
          r.resp = RESP_BADID;
        end
      end
      CMD_ON, CMD_OFF, CMD_SPEED, CMD_GPIO, CMD_PWM, CMD_FWD, CMD_REV, CMD_STATUS,
      CMD_FAULT: begin
        // speed range is checked ahead of the error mode
        if (f == CMD_SPEED && p > MAX_PCT) begin
          r.resp = RESP_RANGE;
        end else if (model_mode == MODE_ERROR) begin
          if (f == CMD_ON) begin
            model_mode   = MODE_STOP;
            r.stop_pulse = 1'b1;
            r.resp       = RESP_OK;
          end else begin
            r.resp = RESP_RECOVER;
          end
        end else if (f == CMD_FAULT) begin
          model_mode   = MODE_ERROR;
          r.stop_pulse = 1'b1;
          r.resp       = RESP_FAULT;
        end else begin
          case (model_mode)
            MODE_STOP: begin
              case (f)
                CMD_ON: begin
                  model_mode  = MODE_PWM;
                  r.pwm_write = 1'b1;
                  r.pwm_value = START_DUTY;
                  r.resp      = RESP_OK;
                end
                CMD_GPIO: begin
                  model_mode = MODE_GPIO;
                  r.resp     = RESP_OK;
                end
                CMD_PWM: begin
                  model_mode = MODE_PWM;
                  r.resp     = RESP_OK;
                end
                default: r.resp = RESP_INVALID;
              endcase
            end
            MODE_PWM: begin
              case (f)
                CMD_OFF: begin
                  model_mode   = MODE_STOP;
                  r.stop_pulse = 1'b1;
                  r.resp       = RESP_OK;
                end
                CMD_SPEED: begin
                  r.pwm_write = 1'b1;
                  r.pwm_value = duty[9:0];
                  r.resp      = RESP_OK;
                end
                CMD_FWD, CMD_REV: r.resp = RESP_OK;
                CMD_GPIO: begin
                  model_mode = MODE_GPIO;
                  r.resp     = RESP_OK;
                end
                CMD_STATUS: r.resp = RESP_STATUS;
                default: r.resp = RESP_INVALID;
              endcase
            end
            MODE_GPIO: begin
              case (f)
                CMD_OFF: begin
                  model_mode   = MODE_STOP;
                  r.stop_pulse = 1'b1;
                  r.resp       = RESP_OK;
                end
                CMD_PWM: begin
                  model_mode = MODE_PWM;
                  r.resp     = RESP_OK;
                end
                CMD_FWD, CMD_REV: r.resp = RESP_OK;
                CMD_STATUS: r.resp = RESP_STATUS;
                default: r.resp = RESP_INVALID;
              endcase
            end
            MODE_FWD, MODE_REV: begin
              case (f)
                CMD_OFF: begin
                  model_mode   = MODE_STOP;
                  r.stop_pulse = 1'b1;
                  r.resp       = RESP_OK;
                end
                CMD_SPEED: begin
                  r.pwm_write = 1'b1;
                  r.pwm_value = duty[9:0];
                  r.resp      = RESP_OK;
                end
                CMD_REV: begin
                  if (model_mode == MODE_FWD) begin
                    model_mode = MODE_REV;
                    r.resp     = RESP_OK;
                  end
                end
                CMD_FWD: begin
                  if (model_mode == MODE_REV) begin
                    model_mode = MODE_FWD;
                    r.resp     = RESP_OK;
                  end
                end
                CMD_GPIO: begin
                  model_mode = MODE_GPIO;
                  r.resp     = RESP_OK;
                end
                CMD_PWM: r.resp = RESP_OK;
                CMD_STATUS: r.resp = RESP_STATUS;
                default: r.resp = RESP_INVALID;
              endcase
            end
            default: r.resp = RESP_INVALID;
          endcase
        end
      end
      default: r.resp = RESP_INVALID;
    endcase
    r.mode        = model_mode;
    r.motor       = model_motor;
    r.loop_closed = model_loop;
    r.rpm         = model_rpm;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("[%0t] response word %0d: %s is %0d, predicted %0d",
             $time, word_idx, what, got, exp_val);
    mismatch_count_o++;
  endtask

  task automatic check_field(string what, int got, int exp_val);
    if (got != exp_val) report_mismatch(what, got, exp_val);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_mode  = MODE_STOP;
      model_motor = 1'b0;
      model_loop  = 1'b0;
      model_rpm   = '0;
      pending_responses.delete();
      word_idx    = 0;
    end else begin
      // retire the oldest prediction first; a word accepted now cannot be out yet
      if (out_valid_i && out_ready_i) begin
        if (pending_responses.size() == 0) begin
          report_mismatch("unpredicted word, resp_code", resp_code_i, -1);
        end else begin
          want = pending_responses.pop_front();
          check_field("resp_code", resp_code_i, want.resp);
          check_field("drive_state", drive_state_i, want.mode);
          check_field("pwm_write", pwm_write_i, want.pwm_write);
          check_field("pwm_value", pwm_value_i, want.pwm_value);
          check_field("stop_pulse", stop_pulse_i, want.stop_pulse);
          check_field("motor_index", motor_index_i, want.motor);
          check_field("loop_reset", loop_reset_i, want.loop_reset);
          check_field("closed_loop", closed_loop_i, want.loop_closed);
          check_field("target_speed", target_speed_i, want.rpm);
        end
        word_idx++;
      end
      if (in_valid_i && in_ready_i) begin
        pending_responses.push_back(predict_response(func_i, param_i));
      end
    end
  end

  initial mismatch_count_o = 0;

endmodule

@@ tb/sv/tb.sv @@
// Top of the motor command mode controller testbench: clock, reset, command
// stimulus and verdict. Needs mcm_pkg, motor_command_mode_fsm and mcm_checker.
`timescale 1ns / 1ps

module tb import mcm_pkg::*;;

  typedef enum int {
    PH_DIRECTED,
    PH_FREE,
    PH_SRC_IDLE,
    PH_SINK_STALL,
    PH_BOTH,
    PH_PRESSURE
  } phase_e;

  localparam int         WATCHDOG_LIMIT = 5000;  // cycles with no word moving
  localparam int         HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int         PHASE_WORDS    = 250;
  localparam logic [3:0] CMD_UNUSED_LO  = 4'd12;
  localparam logic [3:0] CMD_UNUSED_HI  = 4'd15;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [3:0] func_i;
  logic [9:0] param_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [2:0] resp_code_o;
  logic [2:0] drive_state_o;
  logic       pwm_write_o;
  logic [9:0] pwm_value_o;
  logic       stop_pulse_o;
  logic       motor_index_o;
  logic       loop_reset_o;
  logic       closed_loop_o;
  logic [9:0] target_speed_o;

  int     mismatches;
  int     pending;
  phase_e phase;
  int     src_idle_pct;
  int     sink_stall_pct;
  int     quiet_cycles;

  motor_command_mode_fsm i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .param_i        (param_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .resp_code_o    (resp_code_o),
    .drive_state_o  (drive_state_o),
    .pwm_write_o    (pwm_write_o),
    .pwm_value_o    (pwm_value_o),
    .stop_pulse_o   (stop_pulse_o),
    .motor_index_o  (motor_index_o),
    .loop_reset_o   (loop_reset_o),
    .closed_loop_o  (closed_loop_o),
    .target_speed_o (target_speed_o)
  );

  mcm_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .func_i           (func_i),
    .param_i          (param_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .resp_code_i      (resp_code_o),
    .drive_state_i    (drive_state_o),
    .pwm_write_i      (pwm_write_o),
    .pwm_value_i      (pwm_value_o),
    .stop_pulse_i     (stop_pulse_o),
    .motor_index_i    (motor_index_o),
    .loop_reset_i     (loop_reset_o),
    .closed_loop_i    (closed_loop_o),
    .target_speed_i   (target_speed_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Pick the idle and stall rates that go with each phase.
  task automatic set_phase(phase_e ph);
    phase = ph;
    case (ph)
      PH_SRC_IDLE: begin
        src_idle_pct   = 52;
        sink_stall_pct = 0;
      end
      PH_SINK_STALL: begin
        src_idle_pct   = 0;
        sink_stall_pct = 52;
      end
      PH_BOTH: begin
        src_idle_pct   = 24;
        sink_stall_pct = 24;
      end
      default: begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
    endcase
  endtask

  // Offer one command word and hold it until the block takes it. Ready is
  // sampled at the falling edge, where every input has long settled, so the
  // rising edge that follows is the accepting one.
  task automatic send_word(input logic [3:0] f, input logic [9:0] p);
    logic taken;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    param_i    <= p;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Random commands, weighted toward well-formed drive sequences: ON often
  // enough to leave the error mode, fault rare, range and id errors now and
  // then, unused codes as light noise.
  task automatic send_random(int count);
    int unsigned pick;
    logic [3:0]  f;
    logic [9:0]  p;
    repeat (count) begin
      pick = $urandom_range(99);
      p    = 10'($urandom);
      if (pick < 5) begin
        f = 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
      end else if (pick < 8) begin
        f = CMD_FAULT;
      end else if (pick < 20) begin
        f = CMD_ON;
      end else if (pick < 28) begin
        f = CMD_OFF;
      end else if (pick < 45) begin
        f = CMD_SPEED;
        if ($urandom_range(9) != 0) p = 10'($urandom_range(MAX_PCT));
        else p = 10'($urandom_range(1023, MAX_PCT + 1));
      end else if (pick < 52) begin
        f = CMD_GPIO;
      end else if (pick < 59) begin
        f = CMD_PWM;
      end else if (pick < 65) begin
        f = CMD_FWD;
      end else if (pick < 71) begin
        f = CMD_REV;
      end else if (pick < 77) begin
        f = CMD_STATUS;
      end else if (pick < 85) begin
        f = CMD_SETRPM;
        if ($urandom_range(7) != 0) p = 10'($urandom_range(MAX_RPM));
        else p = 10'($urandom_range(1023, MAX_RPM + 1));
      end else if (pick < 90) begin
        f = CMD_AUTO;
      end else begin
        f = CMD_SELECT;
        if ($urandom_range(4) != 0) p = $urandom_range(1) ? MOTOR_TWO_ID : MOTOR_ONE_ID;
      end
      send_word(f, p);
    end
  endtask

  // Receiver: stall at the phase rate; once, in the pressure phase, hold
  // ready low for a long stretch so both registers fill and input stalls.
  initial begin : sink
    bit held;
    held        = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (phase == PH_PRESSURE && !held) begin
        held        = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog: end the run when no word moves on either channel for too long.
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    func_i     = '0;
    param_i    = '0;
    set_phase(PH_DIRECTED);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk through the mode machine and the side commands.
    send_word(CMD_STATUS, 10'd0);       // status while stopped is an invalid event
    send_word(CMD_OFF, 10'd1023);       // off while stopped
    send_word(CMD_ON, 10'd0);           // start with the default duty
    send_word(CMD_SPEED, 10'd0);
    send_word(CMD_SPEED, MAX_PCT);
    send_word(CMD_SPEED, MAX_PCT + 10'd1);
    send_word(CMD_FWD, 10'd0);          // direction in pwm mode keeps the mode
    send_word(CMD_REV, 10'd0);
    send_word(CMD_STATUS, 10'd0);
    send_word(CMD_GPIO, 10'd0);
    send_word(CMD_SPEED, 10'd50);       // speed not allowed in gpio mode
    send_word(CMD_PWM, 10'd0);
    send_word(CMD_OFF, 10'd0);
    send_word(CMD_FAULT, 10'd0);        // enter the error mode
    send_word(CMD_OFF, 10'd0);          // must recover first
    send_word(CMD_SPEED, 10'd1023);     // range check comes ahead of the error mode
    send_word(CMD_SETRPM, MAX_RPM);     // side commands bypass the error mode
    send_word(CMD_SETRPM, MAX_RPM + 10'd1);
    send_word(CMD_SELECT, MOTOR_TWO_ID);
    send_word(CMD_SELECT, 10'd0);       // bad motor id
    send_word(CMD_SELECT, 10'd1023);
    send_word(CMD_AUTO, 10'd0);
    send_word(CMD_ON, 10'd0);           // leave the error mode
    send_word(CMD_UNUSED_HI, 10'd1023);
    send_word(CMD_UNUSED_LO, 10'd0);

    set_phase(PH_FREE);
    send_random(PHASE_WORDS);
    set_phase(PH_SRC_IDLE);
    send_random(PHASE_WORDS);
    set_phase(PH_SINK_STALL);
    send_random(PHASE_WORDS);
    set_phase(PH_BOTH);
    send_random(PHASE_WORDS);
    set_phase(PH_PRESSURE);
    send_random(PHASE_WORDS);
    in_valid_i <= 1'b0;

    // Drain, then give the pipeline time to show any stray word.
    set_phase(PH_FREE);
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ motor_command_mode_fsm.f @@
sv/mcm_pkg.sv
sv/mcm_step.sv
sv/motor_command_mode_fsm.sv
sv/mcm_checker.sv
tb/sv/mcm_checker.sv
tb/sv/tb.sv
